FILE: sv/csa_pkg.sv
package csa_pkg;

  parameter int unsigned CFG_IDX_W = 1;
  parameter int unsigned STEP_W    = 16;

  // configuration register indexes
  parameter logic [CFG_IDX_W-1:0] REG_VALUE_STEP = 1'd0;
  parameter logic [CFG_IDX_W-1:0] REG_SAT_STEP   = 1'd1;

  parameter logic [STEP_W-1:0] VALUE_STEP_RST = 16'd13107;
  parameter logic [STEP_W-1:0] SAT_STEP_RST   = 16'd19661;

  // request types
  parameter logic REQ_DARKEN  = 1'b0;
  parameter logic REQ_LIGHTEN = 1'b1;

  // hexcone sectors
  parameter logic [2:0] SEC_RY = 3'd0;
  parameter logic [2:0] SEC_YG = 3'd1;
  parameter logic [2:0] SEC_GC = 3'd2;
  parameter logic [2:0] SEC_CB = 3'd3;
  parameter logic [2:0] SEC_BM = 3'd4;
  parameter logic [2:0] SEC_MR = 3'd5;

  typedef struct packed {
    logic       req_type;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pix_out_t;

endpackage

FILE: sv/colour_shade_adjust_top.sv
// Colour shade adjust: darkens (lowers V) or lightens (lowers S) one RGB pixel
// through an RGB -> HSV -> RGB round trip in unsigned Q1.FRAC_BITS.
//
// Pixel channel: drive pix_in_i and raise start; the pixel is taken at every
// rising edge where start is high and busy is low. busy stays low, so a pixel
// can be issued in every cycle and the sustained rate is one pixel per clock.
// Result channel: strobe_o is high for one cycle with the adjusted pixel on
// pix_out_o. Each pixel passes through the input register, the pipelined
// restoring dividers for saturation and hue fraction (four quotient bits per
// stage), then adjust, two multiplier stages and the output stage. Results
// come out in input order; the receiver cannot stall them.
// Configuration channel: cfg_valid_i/cfg_ready_o with cfg_index_i
// (0 value step, 1 saturation step) and cfg_wdata_i; cfg_ready_o is always
// high. Write it only while no pixel is in flight.
// Reset clears all valid bits (no strobe follows) and loads the default steps.
module colour_shade_adjust_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  csa_pkg::pix_in_t                    pix_in_i,
  output logic                                strobe_o,
  output csa_pkg::pix_out_t                   pix_out_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [csa_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [csa_pkg::STEP_W-1:0]          cfg_wdata_i
);

  localparam int unsigned FW    = FRAC_BITS + 1;
  localparam int unsigned DIV_W = 8 + FRAC_BITS;
  localparam int unsigned NST   = (DIV_W + 3) / 4;
  localparam int unsigned PAD_W = NST * 4;
  localparam int unsigned LAT   = NST + 5;
  localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;

  typedef struct packed {
    logic             req;
    logic [2:0]       sector;
    logic             szero;
    logic             fzero;
    logic [7:0]       mx;
    logic [7:0]       dl;
    logic [PAD_W-1:0] ds;
    logic [PAD_W-1:0] df;
    logic [7:0]       rs;
    logic [7:0]       rf;
    logic [FW-1:0]    qs;
    logic [FW-1:0]    qf;
  } div_t;

  logic accept;
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // configuration registers
  logic [csa_pkg::STEP_W-1:0] value_step_q, sat_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_step_q <= csa_pkg::VALUE_STEP_RST;
      sat_step_q   <= csa_pkg::SAT_STEP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == csa_pkg::REG_VALUE_STEP) begin
        value_step_q <= cfg_wdata_i;
      end
      if (cfg_index_i == csa_pkg::REG_SAT_STEP) begin
        sat_step_q <= cfg_wdata_i;
      end
    end
  end

  logic [FW-1:0] vstep_f, sstep_f;
  if (FRAC_BITS >= 16) begin : g_step_up
    assign vstep_f = FW'(value_step_q) << (FRAC_BITS - 16);
    assign sstep_f = FW'(sat_step_q) << (FRAC_BITS - 16);
  end else begin : g_step_dn
    assign vstep_f = FW'(value_step_q >> (16 - FRAC_BITS));
    assign sstep_f = FW'(sat_step_q >> (16 - FRAC_BITS));
  end

  // ---------------- stage B: max, min, sector, divider operands
  div_t st_q [NST+1];
  logic vld_q [NST+1];
  div_t b_d;

  always_comb begin
    logic [7:0] r, g, b, mx, mn, dl, hi, lo, num;
    logic [2:0] base, sec;
    r = pix_in_i.red_in;
    g = pix_in_i.green_in;
    b = pix_in_i.blue_in;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dl = mx - mn;
    if (r == mx) begin
      base = csa_pkg::SEC_RY; hi = g; lo = b;
    end else if (g == mx) begin
      base = csa_pkg::SEC_GC; hi = b; lo = r;
    end else begin
      base = csa_pkg::SEC_BM; hi = r; lo = g;
    end
    if (hi >= lo) begin
      num = hi - lo;
      sec = base;
    end else begin
      num = dl - (lo - hi);
      sec = (base == csa_pkg::SEC_RY) ? csa_pkg::SEC_MR : base - 3'd1;
    end
    // fraction reaches one: advance to the next sector
    if (num >= dl && dl != 8'd0) begin
      sec = (sec == csa_pkg::SEC_MR) ? csa_pkg::SEC_RY : sec + 3'd1;
    end
    b_d.req    = pix_in_i.req_type;
    b_d.sector = sec;
    b_d.szero  = (mx == 8'd0);
    b_d.fzero  = (num >= dl);
    b_d.mx     = mx;
    b_d.dl     = dl;
    b_d.ds     = PAD_W'(dl) << FRAC_BITS;
    b_d.df     = PAD_W'(num) << FRAC_BITS;
    b_d.rs     = '0;
    b_d.rf     = '0;
    b_d.qs     = '0;
    b_d.qf     = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= b_d;
  end

  // ---------------- pipelined restoring dividers, four quotient bits a stage
  for (genvar k = 0; k < NST; k++) begin : g_div
    div_t nx;

    always_comb begin
      logic [8:0] cs, cf;
      nx = st_q[k];
      for (int i = 0; i < 4; i++) begin
        cs = {nx.rs, nx.ds[PAD_W-1]};
        cf = {nx.rf, nx.df[PAD_W-1]};
        nx.ds = nx.ds << 1;
        nx.df = nx.df << 1;
        if (cs >= {1'b0, nx.mx}) begin
          nx.rs = 8'(cs - {1'b0, nx.mx});
          nx.qs = {nx.qs[FW-2:0], 1'b1};
        end else begin
          nx.rs = cs[7:0];
          nx.qs = {nx.qs[FW-2:0], 1'b0};
        end
        if (cf >= {1'b0, nx.dl}) begin
          nx.rf = 8'(cf - {1'b0, nx.dl});
          nx.qf = {nx.qf[FW-2:0], 1'b1};
        end else begin
          nx.rf = cf[7:0];
          nx.qf = {nx.qf[FW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[k+1] <= nx;
    end
  end

  // ---------------- stage E: apply step to V or S
  logic          e_vld_q;
  logic [FW-1:0] e_v_q, e_s_q, e_f_q;
  logic [2:0]    e_sec_q;
  logic [FW-1:0] e_v_d, e_s_d, e_f_d, v0, s0;

  always_comb begin
    v0    = FW'({st_q[NST].mx, {(FRAC_BITS-8){1'b0}}});
    s0    = st_q[NST].szero ? '0 : st_q[NST].qs;
    e_f_d = st_q[NST].fzero ? '0 : st_q[NST].qf;
    e_v_d = v0;
    e_s_d = s0;
    if (st_q[NST].req == csa_pkg::REQ_DARKEN) begin
      e_v_d = (v0 > vstep_f) ? v0 - vstep_f : '0;
    end else begin
      e_s_d = (s0 > sstep_f) ? s0 - sstep_f : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else begin
      e_vld_q <= vld_q[NST];
    end
  end

  always_ff @(posedge clk_i) begin
    e_v_q   <= e_v_d;
    e_s_q   <= e_s_d;
    e_f_q   <= e_f_d;
    e_sec_q <= st_q[NST].sector;
  end

  // ---------------- stage F: saturation times fraction
  logic            f_vld_q, f_grey_q;
  logic [FW-1:0]   f_v_q, f_sf_q, f_sg_q, f_oms_q;
  logic [2:0]      f_sec_q;
  logic [2*FW-1:0] prod_sf, prod_sg;

  assign prod_sf = (2*FW)'(e_s_q) * (2*FW)'(e_f_q);
  assign prod_sg = (2*FW)'(e_s_q) * (2*FW)'(ONE - e_f_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else begin
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f_v_q    <= e_v_q;
    f_sec_q  <= e_sec_q;
    f_grey_q <= (e_s_q == '0);
    f_sf_q   <= prod_sf[FRAC_BITS +: FW];
    f_sg_q   <= prod_sg[FRAC_BITS +: FW];
    f_oms_q  <= ONE - e_s_q;
  end

  // ---------------- stage G: p, q, t
  logic            g_vld_q, g_grey_q;
  logic [FW-1:0]   g_v_q, g_p_q, g_qq_q, g_t_q;
  logic [2:0]      g_sec_q;
  logic [2*FW-1:0] prod_p, prod_q, prod_t;

  assign prod_p = (2*FW)'(f_v_q) * (2*FW)'(f_oms_q);
  assign prod_q = (2*FW)'(f_v_q) * (2*FW)'(ONE - f_sf_q);
  assign prod_t = (2*FW)'(f_v_q) * (2*FW)'(ONE - f_sg_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else begin
      g_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    g_v_q    <= f_v_q;
    g_sec_q  <= f_sec_q;
    g_grey_q <= f_grey_q;
    g_p_q    <= prod_p[FRAC_BITS +: FW];
    g_qq_q   <= prod_q[FRAC_BITS +: FW];
    g_t_q    <= prod_t[FRAC_BITS +: FW];
  end

  // ---------------- stage H: sector select, scale to bytes
  logic              h_vld_q, h_grey_q;
  csa_pkg::pix_out_t h_pix_q, h_pix_d;
  logic [FW-1:0]     ro, go, bo;
  logic [FW+7:0]     rw, gw, bw;

  always_comb begin
    ro = g_v_q; go = g_v_q; bo = g_v_q;
    if (!g_grey_q) begin
      case (g_sec_q)
        csa_pkg::SEC_RY: begin ro = g_v_q;  go = g_t_q;  bo = g_p_q;  end
        csa_pkg::SEC_YG: begin ro = g_qq_q; go = g_v_q;  bo = g_p_q;  end
        csa_pkg::SEC_GC: begin ro = g_p_q;  go = g_v_q;  bo = g_t_q;  end
        csa_pkg::SEC_CB: begin ro = g_p_q;  go = g_qq_q; bo = g_v_q;  end
        csa_pkg::SEC_BM: begin ro = g_t_q;  go = g_p_q;  bo = g_v_q;  end
        default:         begin ro = g_v_q;  go = g_p_q;  bo = g_qq_q; end
      endcase
    end
    // chan * 255 as (chan << 8) - chan
    rw = {ro, 8'd0} - (FW+8)'(ro);
    gw = {go, 8'd0} - (FW+8)'(go);
    bw = {bo, 8'd0} - (FW+8)'(bo);
    h_pix_d.red_out   = rw[FRAC_BITS +: 8];
    h_pix_d.green_out = gw[FRAC_BITS +: 8];
    h_pix_d.blue_out  = bw[FRAC_BITS +: 8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_vld_q <= 1'b0;
    end else begin
      h_vld_q <= g_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    h_pix_q  <= h_pix_d;
    h_grey_q <= g_grey_q;
  end

  assign strobe_o  = h_vld_q;
  assign pix_out_o = h_pix_q;

  // ---------------- assertions
  a_lat_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT strobe_o)
    else $error("accepted pixel did not produce a result");

  a_lat_back : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(accept, LAT))
    else $error("result without an accepted pixel");

  a_grey : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && h_grey_q) |->
      (pix_out_o.red_out == pix_out_o.green_out &&
       pix_out_o.green_out == pix_out_o.blue_out))
    else $error("grey path gave unequal channels");

  a_cfg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && cfg_index_i == csa_pkg::REG_VALUE_STEP) |=>
      (value_step_q == $past(cfg_wdata_i)))
    else $error("value step write lost");

endmodule
